// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ctp_pkg.sv =====
// shared constants, types and the column seek function of the transposition cipher
// no dependencies
package ctp_pkg;

  localparam int MSG_DEPTH   = 1024;
  localparam int ADDR_W      = $clog2(MSG_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int KEY_MAX     = 9;
  localparam int COL_W       = 4;
  localparam int DIGIT_W     = 4;
  localparam int KEY_ORDER_W = KEY_MAX * DIGIT_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam int REG_SEL_BIT = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic REG_KEY_LENGTH = 1'b0;
  localparam logic REG_KEY_ORDER  = 1'b1;

  localparam logic [COL_W-1:0]       KEY_LENGTH_RST = COL_W'(1);
  localparam logic [KEY_ORDER_W-1:0] KEY_ORDER_RST  = 36'h987654321;

  typedef struct packed {
    logic [COL_W-1:0]       cols;
    logic [KEY_ORDER_W-1:0] key_order;
  } key_cfg_t;

  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] col;
    logic [LEN_W-1:0] pos;
  } seek_t;

  // first column from col on whose start lies inside the message
  function automatic seek_t col_seek(input logic [COL_W-1:0] col,
                                     input logic [COL_W-1:0] cols,
                                     input logic [KEY_ORDER_W-1:0] korder,
                                     input logic [LEN_W-1:0] len);
    seek_t r;
    logic [DIGIT_W-1:0] d;
    logic [LEN_W-1:0] start;
    r.found = 1'b0;
    r.col   = (col < cols) ? cols : col;
    r.pos   = '0;
    for (int c = KEY_MAX - 1; c >= 0; c--) begin
      d     = korder[c*DIGIT_W +: DIGIT_W];
      start = LEN_W'(d) - LEN_W'(1);
      if (COL_W'(c) >= col && COL_W'(c) < cols && d != '0 && start < len) begin
        r.found = 1'b1;
        r.col   = COL_W'(c);
        r.pos   = start;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/ctp_cfg.sv =====
// configuration registers of the transposition cipher on an apb-style port
// depends on ctp_pkg
module ctp_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ctp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [ctp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [ctp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready,
  output ctp_pkg::key_cfg_t                  key_cfg
);
  import ctp_pkg::*;

  logic [COL_W-1:0]       key_length_r;
  logic [KEY_ORDER_W-1:0] key_order_r;
  logic                   wr_en;
  logic                   reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[REG_SEL_BIT];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LENGTH_RST;
      key_order_r  <= KEY_ORDER_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_KEY_LENGTH: key_length_r <= cfg_pwdata[COL_W-1:0];
        REG_KEY_ORDER:  key_order_r  <= cfg_pwdata[KEY_ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_LENGTH: cfg_prdata = CFG_DATA_W'(key_length_r);
      REG_KEY_ORDER:  cfg_prdata = CFG_DATA_W'(key_order_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // zero counts as one column, anything above the key size as the key size
  always_comb begin
    key_cfg.key_order = key_order_r;
    if (key_length_r == '0) begin
      key_cfg.cols = COL_W'(1);
    end else if (key_length_r > COL_W'(KEY_MAX)) begin
      key_cfg.cols = COL_W'(KEY_MAX);
    end else begin
      key_cfg.cols = key_length_r;
    end
  end

endmodule

// ===== rtl/columnar_transposition_cipher.sv =====
// channel  dir  handshake          payload
// in_      in   tvalid/tready      tuser: operation, tdata: data_byte
// out_     out  tvalid/tready      tdata: cipher_byte, tlast: last_byte
// cfg_     in   psel/penable/pwr   key_length at 0x0, key_order at 0x8
//
// loads transfer back to back while no pull is busy; a pull that yields a byte passes
// the seek (first pull of a read-out only), the store read and the result step, which
// waits for a free output register; a pull that yields nothing ends at the store read
// one single-port-read byte store of 1024 entries with registered read data
// synchronous active-low reset clears control state only, the store is not cleared
// a waiting result sits in the output register while loads still transfer
// depends on ctp_pkg, ctp_cfg
module columnar_transposition_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic [0:0]                     in_tuser,   // [0] operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] cipher_byte
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ctp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ctp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [ctp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import ctp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEEK = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  key_cfg_t key_cfg;

  logic [1:0]       state_r, state_nxt;
  logic             active_r, active_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [LEN_W-1:0] rp_r, rp_nxt;
  logic [LEN_W-1:0] em_r, em_nxt;
  logic             wrap_r, wrap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic [7:0]       rd_data_r;

  logic [7:0]        mem [MSG_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;

  logic             in_fire;
  logic             out_load;
  logic             out_last_nxt;
  logic [LEN_W-1:0] rp_sum;
  logic [COL_W-1:0] col_fin;
  seek_t            sk;

  ctp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .key_cfg     (key_cfg)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sk      = col_seek(col_r, key_cfg.cols, key_cfg.key_order, len_r);
  assign rp_sum  = rp_r + LEN_W'(key_cfg.cols);
  assign col_fin = wrap_r ? sk.col : col_r;

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    len_nxt      = len_r;
    col_nxt      = col_r;
    rp_nxt       = rp_r;
    em_nxt       = em_r;
    wrap_nxt     = wrap_r;
    mem_we       = 1'b0;
    mem_waddr    = len_r[ADDR_W-1:0];
    mem_re       = 1'b0;
    out_load     = 1'b0;
    out_last_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == OP_LOAD) begin
            active_nxt = 1'b0;
            if (active_r) begin
              // new message after a read-out
              mem_we    = 1'b1;
              mem_waddr = '0;
              len_nxt   = LEN_W'(1);
            end else if (len_r < LEN_W'(MSG_DEPTH)) begin
              mem_we  = 1'b1;
              len_nxt = len_r + LEN_W'(1);
            end
          end else if (!active_r) begin
            active_nxt = 1'b1;
            col_nxt    = '0;
            em_nxt     = '0;
            rp_nxt     = '0;
            state_nxt  = ST_SEEK;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_SEEK: begin
        col_nxt = sk.col;
        if (sk.found) begin
          rp_nxt = sk.pos;
        end
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (em_r >= len_r || col_r >= key_cfg.cols || rp_r >= len_r) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_re   = 1'b1;
          em_nxt   = em_r + LEN_W'(1);
          rp_nxt   = rp_sum;
          wrap_nxt = (rp_sum >= len_r);
          if (rp_sum >= len_r) begin
            col_nxt = col_r + COL_W'(1);
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load     = 1'b1;
          out_last_nxt = (em_r >= len_r) || (col_fin >= key_cfg.cols);
          col_nxt      = col_fin;
          if (wrap_r && sk.found) begin
            rp_nxt = sk.pos;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      len_r       <= '0;
      col_r       <= '0;
      rp_r        <= '0;
      em_r        <= '0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      len_r       <= len_nxt;
      col_r       <= col_nxt;
      rp_r        <= rp_nxt;
      em_r        <= em_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rd_data_r;
      out_last_r <= out_last_nxt;
    end
  end

  // message store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[rp_r[ADDR_W-1:0]];
    end
  end

endmodule

// ===== rtl/ctp_checker.sv =====
// port-level checks of the transposition cipher, bound to the top level
// depends on ctp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ctp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [0:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import ctp_pkg::*;

  logic pull_fire;

  assign pull_fire = in_tvalid && in_tready && (in_tuser[0] == OP_PULL);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `ASSERT_CLK(a_pull_busy, clk, rst_n, pull_fire |=> !in_tready, "input ready right after a pull")
  `ASSERT_CLK(a_result_src, clk, rst_n, $rose(out_tvalid) |-> $past(pull_fire, 3) || $past(pull_fire, 4), "result without a matching pull")
  `ASSERT_CLK_NR(a_reset_state, clk, !rst_n |=> !out_tvalid && in_tready, "bad state after reset")

endmodule

bind columnar_transposition_cipher ctp_checker u_ctp_checker (.*);
